[rtl/fld_pkg.sv]
// fld_pkg: shared constants, register codes and controller/datapath structs
// for the flashing lamp detector; no dependencies
`timescale 1ns / 1ps

package fld_pkg;

    // ring of transition times
    localparam int TRANSITION_DEPTH = 16;
    localparam int IDX_W = $clog2(TRANSITION_DEPTH);
    localparam int CNT_W = $clog2(TRANSITION_DEPTH + 1);

    // payload widths
    localparam int TIME_W   = 32;
    localparam int LAMP_W   = 2;
    localparam int OCNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int MS_W     = 16;
    localparam int MINC_W   = 5;

    // lamp codes
    localparam logic [LAMP_W-1:0] LAMP_UNKNOWN = 2'd0;
    localparam logic [LAMP_W-1:0] LAMP_OFF     = 2'd1;
    localparam logic [LAMP_W-1:0] LAMP_ON      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_QUIET  = 2'd3;

    // configuration reset values
    localparam logic [MS_W-1:0]   RST_HISTORY_WINDOW = 16'd3000;
    localparam logic [MINC_W-1:0] RST_MIN_COUNT      = 5'd4;
    localparam logic [MS_W-1:0]   RST_MIN_SPAN       = 16'd1500;
    localparam logic [MS_W-1:0]   RST_RELEASE_QUIET  = 16'd2000;

    // controller to datapath commands
    typedef struct packed {
        logic latch;    // capture input transfer
        logic update;   // lamp update and ring push
        logic pop;      // drop oldest entry, read the next one
        logic decide;   // evaluate flashing flag
        logic load;     // load output register
    } fld_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic expired;
        logic out_busy;
    } fld_sts_t;

endpackage

[rtl/fld_ctrl.sv]
// fld_ctrl: sequencing state machine of the flashing lamp detector
// depends on fld_pkg (command and status structs)
`timescale 1ns / 1ps

module fld_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  fld_pkg::fld_sts_t sts,
    output fld_pkg::fld_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // input taken only while idle
    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = sts.count_zero ? S_DECIDE : S_CMP;
            end
            S_CMP:
            begin
                if (sts.expired)
                begin
                    cmd.pop = 1'b1;
                    if (sts.count_one)
                        state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/fld_datapath.sv]
// fld_datapath: configuration registers, lamp state, transition ring memory,
// expiry compare, flag logic and output register; depends on fld_pkg
`timescale 1ns / 1ps

module fld_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fld_pkg::fld_cmd_t                   cmd,
    output fld_pkg::fld_sts_t                   sts,
    input  logic [fld_pkg::TIME_W-1:0]          stamp_ms,
    input  logic [fld_pkg::LAMP_W-1:0]          lamp_state,
    input  logic                                cfg_wr,
    input  logic [fld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fld_pkg::CFG_DAT_W-1:0]       cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                flashing,
    output logic [fld_pkg::OCNT_W-1:0]          transition_count
);

    localparam int DEPTH = fld_pkg::TRANSITION_DEPTH;
    localparam int IW    = fld_pkg::IDX_W;
    localparam int CW    = fld_pkg::CNT_W;
    localparam int TW    = fld_pkg::TIME_W;
    localparam int SW    = CW + 1;

    // configuration registers
    logic [fld_pkg::MS_W-1:0]   window_reg;
    logic [fld_pkg::MINC_W-1:0] min_count_reg;
    logic [fld_pkg::MS_W-1:0]   min_span_reg;
    logic [fld_pkg::MS_W-1:0]   quiet_reg;

    // item and detector state
    logic [TW-1:0]                 now_reg;
    logic [fld_pkg::LAMP_W-1:0]    code_reg;
    logic                          lamp_reg;
    logic                          lamp_valid_reg;
    logic                          change_valid_reg;
    logic [TW-1:0]                 change_ms_reg;
    logic [IW-1:0]                 head_reg;
    logic [IW-1:0]                 head_next;
    logic [CW-1:0]                 count_reg;
    logic                          flag_reg;
    logic [TW-1:0]                 rd_data_reg;
    logic                          out_valid_reg;
    logic                          out_flash_reg;
    logic [fld_pkg::OCNT_W-1:0]    out_count_reg;

    // transition ring
    logic [TW-1:0] times_mem [DEPTH];

    logic          known;
    logic          new_lamp;
    logic          transition;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] rd_idx;
    logic [SW-1:0] wr_sum;
    logic          full;
    logic [TW-1:0] age;
    logic [TW-1:0] span;
    logic [TW-1:0] quiet;
    logic          flag_set;
    logic          flag_clr;

    // lamp decode and transition detect
    assign known      = (code_reg == fld_pkg::LAMP_OFF) || (code_reg == fld_pkg::LAMP_ON);
    assign new_lamp   = (code_reg == fld_pkg::LAMP_ON);
    assign transition = known && lamp_valid_reg && (lamp_reg != new_lamp);
    assign full       = (count_reg == CW'(DEPTH));

    // ring indexes with wrap
    always_comb
    begin
        wr_sum = SW'(head_reg) + SW'(count_reg);
        if (wr_sum >= SW'(DEPTH))
            wr_sum = wr_sum - SW'(DEPTH);
        wr_idx = wr_sum[IW-1:0];
        if (head_reg == IW'(DEPTH - 1))
            head_next = '0;
        else
            head_next = head_reg + 1'b1;
        rd_idx = cmd.pop ? head_next : head_reg;
    end

    // age and span arithmetic
    assign age   = now_reg - rd_data_reg;
    assign span  = change_ms_reg - rd_data_reg;
    assign quiet = now_reg - change_ms_reg;

    assign flag_set = (count_reg != '0) && (count_reg >= CW'(min_count_reg))
                      && (span >= TW'(min_span_reg));
    assign flag_clr = !change_valid_reg || (quiet > TW'(quiet_reg));

    // status to controller
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_one  = (count_reg == CW'(1));
    assign sts.expired    = (age > TW'(window_reg));
    assign sts.out_busy   = out_valid_reg && out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= fld_pkg::RST_HISTORY_WINDOW;
            min_count_reg <= fld_pkg::RST_MIN_COUNT;
            min_span_reg  <= fld_pkg::RST_MIN_SPAN;
            quiet_reg     <= fld_pkg::RST_RELEASE_QUIET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                fld_pkg::CFG_HISTORY_WINDOW: window_reg    <= cfg_data;
                fld_pkg::CFG_MIN_COUNT:      min_count_reg <= cfg_data[fld_pkg::MINC_W-1:0];
                fld_pkg::CFG_MIN_SPAN:       min_span_reg  <= cfg_data;
                fld_pkg::CFG_RELEASE_QUIET:  quiet_reg     <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            now_reg  <= stamp_ms;
            code_reg <= lamp_state;
        end
    end

    // lamp state, ring pointers and flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_reg         <= 1'b0;
            lamp_valid_reg   <= 1'b0;
            change_valid_reg <= 1'b0;
            change_ms_reg    <= '0;
            head_reg         <= '0;
            count_reg        <= '0;
            flag_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.update && known)
            begin
                lamp_reg       <= new_lamp;
                lamp_valid_reg <= 1'b1;
                if (transition)
                begin
                    change_ms_reg    <= now_reg;
                    change_valid_reg <= 1'b1;
                    if (full)
                        head_reg <= head_next;
                    else
                        count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.pop)
            begin
                head_reg  <= head_next;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.decide)
            begin
                if (!flag_reg)
                    flag_reg <= flag_set;
                else if (flag_clr)
                    flag_reg <= 1'b0;
            end
        end
    end

    // ring memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.update && transition)
            times_mem[wr_idx] <= now_reg;
        rd_data_reg <= times_mem[rd_idx];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_flash_reg <= flag_reg;
            out_count_reg <= fld_pkg::OCNT_W'(count_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign flashing         = out_flash_reg;
    assign transition_count = out_count_reg;

endmodule

[rtl/flashing_lamp_detector_unit.sv]
// flashing_lamp_detector_unit: top level joining controller and datapath
// depends on fld_pkg, fld_ctrl, fld_datapath
//
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, stamp_ms, lamp_state | item in, stall out
//  out     | out_valid, out_stall, flashing,          | result out, stall in
//          | transition_count                         |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| write in, always ready
//
// an item passes the update, read, expiry compare (none for an empty ring),
// decide and output states; no new item is taken before its result is loaded.
// The compare runs once per expired entry, plus once if one stays (at most 16).
// rst_n clears control, lamp state, ring pointers and loads register defaults;
// the ring memory itself is not cleared, only counted entries are read.
// a result waits in the output register; while out_stall holds it, the item
// in flight waits in its last state and in_stall stays high.
`timescale 1ns / 1ps

module flashing_lamp_detector_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fld_pkg::TIME_W-1:0]        stamp_ms,
    input  logic [fld_pkg::LAMP_W-1:0]        lamp_state,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              flashing,
    output logic [fld_pkg::OCNT_W-1:0]        transition_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fld_pkg::CFG_DAT_W-1:0]     cfg_data
);

    fld_pkg::fld_cmd_t cmd;
    fld_pkg::fld_sts_t sts;

    // configuration writes accepted at any time
    assign cfg_ready = 1'b1;

    // sequencer
    fld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    fld_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .stamp_ms         (stamp_ms),
        .lamp_state       (lamp_state),
        .cfg_wr           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .flashing         (flashing),
        .transition_count (transition_count)
    );

endmodule
